>>> rtl/core/pdbm_pkg.sv
// Shared types and constants for the phase difference bin mean block.
`default_nettype none
package pdbm_pkg;

  localparam int unsigned SampleWidth  = 16;
  localparam int unsigned MaxBinLength = 4096;
  localparam int unsigned CfgWidth     = 13;
  localparam int unsigned SumWidth     = 29;
  localparam int unsigned QWidth       = 16;
  // Widest normalizer operand: product components and bin sums.
  localparam int unsigned VecWidth     = 34;
  localparam int unsigned MagWidth     = VecWidth - 1;
  localparam int unsigned SqWidth      = 2 * MagWidth + 1;
  localparam int unsigned RootWidth    = (SqWidth + 1) / 2;
  localparam int unsigned NumWidth     = MagWidth + QWidth;
  localparam int unsigned QuoWidth     = QWidth + 2;
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QueuePtrW    = 2;

  localparam logic [0:0] RegBinLength = 1'b0;
  localparam logic [0:0] RegBinCount  = 1'b1;

  // Item handed from the front part to the back part.
  typedef struct packed {
    logic signed [VecWidth-1:0] dr;
    logic signed [VecWidth-1:0] di;
    logic                       block_start;
  } item_t;

  // Normalizer request and result.
  typedef struct packed {
    logic signed [VecWidth-1:0] x;
    logic signed [VecWidth-1:0] y;
  } vec_t;

  typedef struct packed {
    logic signed [QWidth-1:0] ux;
    logic signed [QWidth-1:0] uy;
    logic                     zero;
  } unit_t;

  typedef struct packed {
    logic signed [QWidth-1:0] diff_re;
    logic signed [QWidth-1:0] diff_im;
    logic                     diff_zero;
    logic                     bin_done;
    logic signed [QWidth-1:0] mean_re;
    logic signed [QWidth-1:0] mean_im;
    logic                     mean_zero;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/core/pdbm_norm.sv
// Sequential normalizer: integer square root, then two restoring divisions.
`default_nettype none
module pdbm_norm (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  pdbm_pkg::vec_t vec_i,
  output logic          busy_o,
  output logic          done_o,
  output pdbm_pkg::unit_t unit_o
);
  import pdbm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SQRT = 4'b0010,
    S_DIVX = 4'b0100,
    S_DIVY = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [SqWidth-1:0]   s_q;
  logic [SqWidth-1:0]   r_q;
  logic [SqWidth-1:0]   bit_q;
  logic [RootWidth-1:0] m_q;
  logic [NumWidth-1:0]  num_q;
  logic [QuoWidth+MagWidth:0] rem_q;
  logic [QuoWidth-1:0]  quo_q;
  logic [6:0]           cnt_q;
  logic                 negx_q, negy_q;
  logic [MagWidth-1:0]  ay_q;
  logic signed [QWidth-1:0] ux_q;
  logic                 done_q;
  unit_t                unit_q;

  logic [MagWidth-1:0] ax_w, ay_w;
  logic [SqWidth-1:0]  sq_w;
  logic [SqWidth-1:0]  trial_w;
  logic [QuoWidth+MagWidth:0] rsh_w;
  logic [QuoWidth+MagWidth:0] rsub_w;
  logic signed [QWidth-1:0] sat_w;
  logic [QuoWidth-1:0] qf_w;

  assign ax_w = vec_i.x[VecWidth-1] ? MagWidth'(-vec_i.x) : vec_i.x[MagWidth-1:0];
  assign ay_w = vec_i.y[VecWidth-1] ? MagWidth'(-vec_i.y) : vec_i.y[MagWidth-1:0];
  assign sq_w = SqWidth'(ax_w) * SqWidth'(ax_w) + SqWidth'(ay_w) * SqWidth'(ay_w);
  assign trial_w = r_q + bit_q;

  // Restoring divide step: numerator bits shift into the remainder.
  assign rsh_w  = {rem_q[QuoWidth+MagWidth-1:0], num_q[NumWidth-1]};
  assign rsub_w = rsh_w - (QuoWidth+MagWidth+1)'(m_q);

  // Final step result, then the sign and saturation; rounding half up on the magnitude comes from the numerator.
  always_comb begin
    qf_w = {quo_q[QuoWidth-2:0], ~rsub_w[QuoWidth+MagWidth]};
    sat_w = '0;
    if (state_q == S_DIVY ? negy_q : negx_q) begin
      if (qf_w > QuoWidth'(32768)) sat_w = -16'sd32768;
      else sat_w = QWidth'(-$signed({1'b0, qf_w}));
    end else begin
      if (qf_w > QuoWidth'(32767)) sat_w = 16'sd32767;
      else sat_w = qf_w[QWidth-1:0];
    end
  end

  // A zero vector leaves the square root with a zero root and skips the divisions.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start_i) state_d = S_SQRT;
      S_SQRT: if (bit_q == '0) state_d = (r_q == '0) ? S_IDLE : S_DIVX;
      S_DIVX: if (cnt_q == '0) state_d = S_DIVY;
      S_DIVY: if (cnt_q == '0) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Numerator |v|*32768 + m/2 is built with the rounding term added up front.
  function automatic logic [NumWidth-1:0] numer(input logic [MagWidth-1:0] a,
                                               input logic [RootWidth-1:0] m);
    numer = {1'b0, a, {QWidth-1{1'b0}}} + NumWidth'(m >> 1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_DIVY && cnt_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          s_q    <= sq_w;
          r_q    <= '0;
          bit_q  <= SqWidth'(1) << (SqWidth - 1 - ((SqWidth - 1) % 2));
          negx_q <= vec_i.x[VecWidth-1];
          negy_q <= vec_i.y[VecWidth-1];
          num_q  <= {ax_w, {QWidth{1'b0}}};
          ay_q   <= ay_w;
        end
      end
      S_SQRT: begin
        if (bit_q != '0) begin
          if (s_q >= trial_w) begin
            s_q <= s_q - trial_w;
            r_q <= (r_q >> 1) + bit_q;
          end else begin
            r_q <= r_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end else begin
          m_q   <= r_q[RootWidth-1:0];
          num_q <= numer(num_q[NumWidth-1:QWidth], r_q[RootWidth-1:0]);
          rem_q <= '0;
          quo_q <= '0;
          cnt_q <= 7'(NumWidth - 1);
        end
      end
      S_DIVX, S_DIVY: begin
        if (cnt_q == '0 && state_q == S_DIVX) begin
          ux_q  <= sat_w;
          num_q <= numer(ay_q, m_q);
          rem_q <= '0;
          quo_q <= '0;
          cnt_q <= 7'(NumWidth - 1);
        end else begin
          rem_q <= rsub_w[QuoWidth+MagWidth] ? rsh_w : rsub_w;
          num_q <= num_q << 1;
          quo_q <= {quo_q[QuoWidth-2:0], ~rsub_w[QuoWidth+MagWidth]};
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == '0) begin
            unit_q.ux   <= ux_q;
            unit_q.uy   <= sat_w;
            unit_q.zero <= 1'b0;
          end
        end
      end
      default: ;
    endcase
    // Zero vector: m is zero, so report it directly.
    if (state_q == S_SQRT && bit_q == '0 && r_q == '0) begin
      unit_q <= '{ux: '0, uy: '0, zero: 1'b1};
    end
  end

  // A zero vector skips the divisions.
  logic zero_done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) zero_done_q <= 1'b0;
    else zero_done_q <= (state_q == S_SQRT && bit_q == '0 && r_q == '0);
  end

  assign busy_o = (state_q != S_IDLE) || done_q || zero_done_q;
  assign done_o = done_q || zero_done_q;
  assign unit_o = unit_q;
endmodule
`default_nettype wire

>>> rtl/core/pdbm_front.sv
// Front part: accepts sample pairs and forms the complex product a*conj(b).
`default_nettype none
module pdbm_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [pdbm_pkg::SampleWidth-1:0] a_re_i,
  input  logic signed [pdbm_pkg::SampleWidth-1:0] a_im_i,
  input  logic signed [pdbm_pkg::SampleWidth-1:0] b_re_i,
  input  logic signed [pdbm_pkg::SampleWidth-1:0] b_im_i,
  input  logic                                  block_start_i,
  output logic                                  push_o,
  output pdbm_pkg::item_t                       item_o,
  input  logic                                  full_i
);
  import pdbm_pkg::*;

  logic                         v_q;
  logic signed [2*SampleWidth-1:0] p0_q, p1_q, p2_q, p3_q;
  logic                         bs_q;

  assign in_ready_o = !v_q || !full_i;
  assign push_o     = v_q && !full_i;
  assign item_o.dr  = VecWidth'(p0_q) + VecWidth'(p1_q);
  assign item_o.di  = VecWidth'(p2_q) - VecWidth'(p3_q);
  assign item_o.block_start = bs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else if (in_ready_o) v_q <= in_valid_i;
  end

  // Register the four partial products.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      p0_q <= a_re_i * b_re_i;
      p1_q <= a_im_i * b_im_i;
      p2_q <= a_im_i * b_re_i;
      p3_q <= a_re_i * b_im_i;
      bs_q <= block_start_i;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/pdbm_queue.sv
// Short queue between front and back parts.
`default_nettype none
module pdbm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pdbm_pkg::item_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output pdbm_pkg::item_t data_o
);
  import pdbm_pkg::*;

  item_t mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wp_q, rp_q;
  logic [QueuePtrW:0]   cnt_q;

  assign full_o  = cnt_q == (QueuePtrW+1)'(QueueDepth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QueuePtrW+1)'(push_i) - (QueuePtrW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end
endmodule
`default_nettype wire

>>> rtl/core/pdbm_back.sv
// Back part: normalizes the product, accumulates bins and forms the bin mean.
`default_nettype none
module pdbm_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [pdbm_pkg::CfgWidth-1:0]    bin_length_i,
  input  logic [pdbm_pkg::CfgWidth-1:0]    bin_count_i,
  input  logic                             empty_i,
  input  pdbm_pkg::item_t                  item_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output pdbm_pkg::result_t                res_o
);
  import pdbm_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_PHS   = 5'b00010,
    B_ACC   = 5'b00100,
    B_MEAN  = 5'b01000,
    B_OUT   = 5'b10000
  } bstate_e;

  bstate_e st_q;
  logic signed [SumWidth-1:0] sr_q, si_q;
  logic [CfgWidth-1:0] sib_q, bf_q;
  result_t res_q;
  logic out_q;

  logic  nstart, nbusy, ndone;
  vec_t  nvec;
  unit_t nunit;

  pdbm_norm u_norm (
    .clk_i, .rst_ni, .start_i(nstart), .vec_i(nvec),
    .busy_o(nbusy), .done_o(ndone), .unit_o(nunit)
  );

  logic [CfgWidth-1:0] len_w;
  always_comb begin
    len_w = bin_length_i;
    if (len_w == '0) len_w = CfgWidth'(1);
    if (len_w > CfgWidth'(MaxBinLength)) len_w = CfgWidth'(MaxBinLength);
  end

  logic signed [SumWidth-1:0] nsr_w, nsi_w;
  logic [CfgWidth-1:0] nsib_w;
  assign nsr_w  = sr_q + SumWidth'(res_q.diff_re);
  assign nsi_w  = si_q + SumWidth'(res_q.diff_im);
  assign nsib_w = sib_q + 1'b1;

  assign pop_o  = (st_q == B_IDLE) && !empty_i && !nbusy;
  assign nstart = pop_o || (st_q == B_ACC && bf_q < bin_count_i && nsib_w >= len_w);
  assign nvec.x = pop_o ? item_i.dr : VecWidth'(nsr_w);
  assign nvec.y = pop_o ? item_i.di : VecWidth'(nsi_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_IDLE; out_q <= 1'b0;
      sr_q <= '0; si_q <= '0; sib_q <= '0; bf_q <= '0;
    end else begin
      if (st_q == B_OUT && (!out_q || out_ready_i)) out_q <= 1'b1;
      else if (out_ready_i) out_q <= 1'b0;
      case (st_q)
        B_IDLE: if (pop_o) begin
          st_q <= B_PHS;
          if (item_i.block_start) begin
            sr_q <= '0; si_q <= '0; sib_q <= '0; bf_q <= '0;
          end
        end
        B_PHS: if (ndone) st_q <= B_ACC;
        B_ACC: begin
          if (bf_q < bin_count_i) begin
            if (nsib_w >= len_w) begin
              sr_q <= '0; si_q <= '0; sib_q <= '0; bf_q <= bf_q + 1'b1;
              st_q <= B_MEAN;
            end else begin
              sr_q <= nsr_w; si_q <= nsi_w; sib_q <= nsib_w;
              st_q <= B_OUT;
            end
          end else st_q <= B_OUT;
        end
        B_MEAN: if (ndone) st_q <= B_OUT;
        B_OUT: if (!out_q || out_ready_i) st_q <= B_IDLE;
        default: st_q <= B_IDLE;
      endcase
    end
  end

  // Hold the result while it is being built and until the transfer.
  always_ff @(posedge clk_i) begin
    if (st_q == B_PHS && ndone) begin
      res_q.diff_re <= nunit.ux; res_q.diff_im <= nunit.uy;
      res_q.diff_zero <= nunit.zero;
      res_q.bin_done <= 1'b0; res_q.mean_re <= '0; res_q.mean_im <= '0;
      res_q.mean_zero <= 1'b0;
    end
    if (st_q == B_MEAN && ndone) begin
      res_q.bin_done <= 1'b1; res_q.mean_re <= nunit.ux;
      res_q.mean_im <= nunit.uy; res_q.mean_zero <= nunit.zero;
    end
  end

  // Output register apart from the working copy.
  result_t ores_q;
  always_ff @(posedge clk_i) begin
    if (st_q == B_OUT && (!out_q || out_ready_i)) ores_q <= res_q;
  end

  assign out_valid_o = out_q;
  assign res_o       = ores_q;
endmodule
`default_nettype wire

>>> rtl/core/phase_difference_bin_mean.sv
// Top level of the phase difference bin mean block.
// Usage:
//  - Input channel s_axis_*: one transfer carries a pair of complex samples
//    a and b; tuser is block_start, which clears the bin sums and counters.
//  - Output channel m_axis_*: one transfer per input sample with the unit
//    phasor of a*conj(b) and, when this sample closed a bin, the bin mean.
//  - Config port: cfg_we_i writes bin_length (index 0) or bin_count (1);
//    write only while the block is idle.
// Structure: the front stage registers the four products and hands items
//  to a four-entry queue. The back part runs one shared sequential
//  normalizer, an integer square root and two restoring divides, and pops
//  the next item only once the last is through it; a sample that closes
//  a bin runs it twice. A zero vector skips the divides. That
//  normalizer sets the rate.
// Reset: asynchronous, active low; clears sums, counters, the queue and the
//  output valid flag; bin_length returns to 64 and bin_count to 1.
// Stall: a result waits in the output register while the next item is
//  worked on; the queue fills and then the input deasserts tready.
`default_nettype none
module phase_difference_bin_mean (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // a_re [15:0], a_im [31:16], b_re [47:32], b_im [63:48]
  input  logic [63:0] s_axis_tdata,
  // block_start
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // diff_re [15:0], diff_im [31:16], diff_zero [32], bin_done [33],
  // mean_re [49:34], mean_im [65:50], mean_zero [66], zero fill [71:67]
  output logic [71:0] m_axis_tdata
);
  import pdbm_pkg::*;

  logic [CfgWidth-1:0] bin_length_q, bin_count_q;

  // Hold configuration; apply writes by index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_length_q <= CfgWidth'(64);
      bin_count_q  <= CfgWidth'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegBinLength: bin_length_q <= cfg_data_i;
        RegBinCount:  bin_count_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic  push, full, pop, empty;
  item_t fitem, qitem;
  result_t res;

  pdbm_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .a_re_i(s_axis_tdata[15:0]), .a_im_i(s_axis_tdata[31:16]),
    .b_re_i(s_axis_tdata[47:32]), .b_im_i(s_axis_tdata[63:48]),
    .block_start_i(s_axis_tuser),
    .push_o(push), .item_o(fitem), .full_i(full)
  );

  pdbm_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(fitem), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(qitem)
  );

  pdbm_back u_back (
    .clk_i, .rst_ni,
    .bin_length_i(bin_length_q), .bin_count_i(bin_count_q),
    .empty_i(empty), .item_i(qitem), .pop_o(pop),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {5'b0, res.mean_zero, res.mean_im, res.mean_re, res.bin_done,
                         res.diff_zero, res.diff_im, res.diff_re};

  // Never push into a full queue or pop an empty one.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty |-> !pop) else $error("pop from empty queue");
  // The mean fields stay zero unless the sample closed a bin.
  a_mean_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !res.bin_done) |-> (res.mean_re == '0 && res.mean_im == '0
    && !res.mean_zero)) else $error("mean without bin end");
endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the phase difference bin mean block.
`default_nettype none
module tb;
  import pdbm_pkg::*;

  // Expected output of one sample transfer.
  typedef struct {
    logic signed [15:0] diff_re;
    logic signed [15:0] diff_im;
    logic               diff_zero;
    logic               bin_done;
    logic signed [15:0] mean_re;
    logic signed [15:0] mean_im;
    logic               mean_zero;
  } phasor_out_t;

  // Predicts the block and holds the outputs still to come.
  class phasor_scoreboard;
    logic [12:0]        len_reg;
    logic [12:0]        cnt_reg;
    longint             acc_re, acc_im;
    int unsigned        fill, bins_closed;
    phasor_out_t        pending[$];
    int                 errors;

    function new();
      len_reg = 13'd64;
      cnt_reg = 13'd1;
      acc_re = 0;
      acc_im = 0;
      fill = 0;
      bins_closed = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [12:0] val);
      if (idx == RegBinLength) len_reg = val;
      else cnt_reg = val;
    endfunction

    function longint root_floor(longint unsigned s);
      longint unsigned r, bit_w;
      r = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > s) bit_w >>= 2;
      while (bit_w != 0) begin
        if (s >= r + bit_w) begin
          s -= r + bit_w;
          r = (r >> 1) + bit_w;
        end else begin
          r >>= 1;
        end
        bit_w >>= 2;
      end
      return longint'(r);
    endfunction

    function logic signed [15:0] to_q15(longint x, longint m);
      longint mag, q;
      mag = (x < 0) ? -x : x;
      q = (mag * 32768 + m / 2) / m;
      if (x < 0) return (q > 32768) ? -16'sd32768 : 16'(-q);
      return (q > 32767) ? 16'sd32767 : 16'(q);
    endfunction

    // Normalize (x, y); returns 1 for the zero vector.
    function logic normalize(longint x, longint y, output logic signed [15:0] ux,
                             output logic signed [15:0] uy);
      longint m;
      ux = 0;
      uy = 0;
      if (x == 0 && y == 0) return 1'b1;
      m = root_floor(longint'(x * x + y * y));
      ux = to_q15(x, m);
      uy = to_q15(y, m);
      return 1'b0;
    endfunction

    function void note_sample(logic [63:0] data, logic start);
      longint ar, ai, br, bi, dr, di, eff_len;
      phasor_out_t o;
      ar = longint'($signed(data[15:0]));
      ai = longint'($signed(data[31:16]));
      br = longint'($signed(data[47:32]));
      bi = longint'($signed(data[63:48]));
      dr = ar * br + ai * bi;
      di = ai * br - ar * bi;
      eff_len = (len_reg == 0) ? 1 : (len_reg > 4096) ? 4096 : len_reg;
      if (start) begin
        acc_re = 0;
        acc_im = 0;
        fill = 0;
        bins_closed = 0;
      end
      o.diff_zero = normalize(dr, di, o.diff_re, o.diff_im);
      o.bin_done = 0;
      o.mean_re = 0;
      o.mean_im = 0;
      o.mean_zero = 0;
      if (bins_closed < cnt_reg) begin
        acc_re += o.diff_re;
        acc_im += o.diff_im;
        fill++;
        if (fill >= eff_len) begin
          o.bin_done = 1;
          o.mean_zero = normalize(acc_re, acc_im, o.mean_re, o.mean_im);
          bins_closed++;
          acc_re = 0;
          acc_im = 0;
          fill = 0;
        end
      end
      pending.push_back(o);
    endfunction

    function void check_result(logic [71:0] d);
      phasor_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[15:0] !== e.diff_re) begin
        $error("diff_re exp %0d got %0d", e.diff_re, $signed(d[15:0])); errors++;
      end
      if (d[31:16] !== e.diff_im) begin
        $error("diff_im exp %0d got %0d", e.diff_im, $signed(d[31:16])); errors++;
      end
      if (d[32] !== e.diff_zero) begin
        $error("diff_zero exp %0b got %0b", e.diff_zero, d[32]); errors++;
      end
      if (d[33] !== e.bin_done) begin
        $error("bin_done exp %0b got %0b", e.bin_done, d[33]); errors++;
      end
      if (d[49:34] !== e.mean_re) begin
        $error("mean_re exp %0d got %0d", e.mean_re, $signed(d[49:34])); errors++;
      end
      if (d[65:50] !== e.mean_im) begin
        $error("mean_im exp %0d got %0d", e.mean_im, $signed(d[65:50])); errors++;
      end
      if (d[66] !== e.mean_zero) begin
        $error("mean_zero exp %0b got %0b", e.mean_zero, d[66]); errors++;
      end
      if (d[71:67] !== 5'd0) begin
        $error("zero fill exp 0 got %0h", d[71:67]); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = RegBinLength;
  logic [12:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  phasor_scoreboard sb = new();
  bit          hold_off = 1'b0;   // long receiver stall requested by stimulus

  phase_difference_bin_mean uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  // Check every output transfer at the edge where it happens.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Receiver: stall pattern with calm stretches, plus the long hold-off.
  initial begin : receiver
    int mode, n;
    forever begin
      mode = $urandom_range(0, 2);
      n = $urandom_range(20, 400);
      repeat (n) begin
        @(posedge clk_i);
        if (hold_off) m_axis_tready <= 1'b0;
        else if (mode == 0) m_axis_tready <= 1'b1;
        else if (mode == 1) m_axis_tready <= ($urandom_range(0, 3) != 0);
        else m_axis_tready <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // Offer one sample and hold it until the transfer completes.
  task automatic send_sample(logic [63:0] data, logic start);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(data, start);
  endtask

  task automatic end_burst();
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 300);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drain, then give the normalizer time to go quiet.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [12:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_pair();
    if ($urandom_range(0, 15) == 0) return {16'd0, 16'd0, rand_comp(), rand_comp()};
    return {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
  endfunction

  // Random phase of n samples in bursts; block start is set at random, on one sample in 25 on average.
  task automatic random_phase(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        if (n > 0) begin
          send_sample(rand_pair(), $urandom_range(0, 24) == 0);
          n--;
        end
      end
      end_burst();
    end
  endtask

  initial begin : stimulus
    logic [63:0] dir [12];
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: two short bins of four samples over the extremes, then samples past them.
    write_reg(RegBinLength, 13'd4);
    write_reg(RegBinCount, 13'd2);
    dir = '{64'h8000_8000_8000_8000, 64'h7fff_7fff_7fff_7fff,
            64'h0000_0000_0000_0000, 64'h8000_7fff_7fff_8000,
            64'h0000_0001_0000_0001, 64'h0000_8000_0000_7fff,
            // opposite phasors; the second pair already falls past the last bin
            64'h0000_0001_0000_0001, 64'h0000_ffff_0000_0001,
            64'h0000_0001_0000_0001, 64'h0000_ffff_0000_0001,
            // past the last bin
            64'h1234_5678_9abc_def0, 64'h0000_0000_7fff_7fff};
    send_sample(dir[0], 1'b1);
    for (int i = 1; i < 12; i++) send_sample(dir[i], 1'b0);
    wait_idle();

    // Bin count zero and bin length zero.
    write_reg(RegBinCount, 13'd0);
    write_reg(RegBinLength, 13'd0);
    for (int i = 0; i < 4; i++) send_sample(rand_pair(), i == 0);
    wait_idle();
    write_reg(RegBinCount, 13'd3);
    for (int i = 0; i < 4; i++) send_sample(rand_pair(), i == 0);
    wait_idle();

    // Random phases over several settings.
    write_reg(RegBinLength, 13'd1);
    write_reg(RegBinCount, 13'd8191);
    random_phase(200);
    wait_idle();

    write_reg(RegBinLength, 13'd5);
    write_reg(RegBinCount, 13'd40);
    // Long receiver hold-off while the sender keeps offering.
    fork
      begin
        hold_off = 1'b1;
        repeat (2000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_phase(300);
    join
    wait_idle();

    write_reg(RegBinLength, 13'd8191);   // acts as the maximum length
    write_reg(RegBinCount, 13'd1);
    random_phase(100);
    wait_idle();

    write_reg(RegBinLength, 13'd4096);
    write_reg(RegBinCount, 13'd4096);
    random_phase(200);
    wait_idle();

    write_reg(RegBinLength, 13'd3);
    write_reg(RegBinCount, 13'd5);
    random_phase(530);
    wait_idle();

    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin : watchdog
    #40000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire
